// ===== hdl/ffea_pkg.sv =====
// Shared types and constants of the first-fit extent allocator.
// Used by ffea_ctrl, ffea_dpath and the top level; depends on nothing.
`default_nettype none
package ffea_pkg;

  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ENTRY_W  = 64;  // {base, size}

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERLAP = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

  localparam logic CFG_REGION_START  = 1'b0;
  localparam logic CFG_REGION_LENGTH = 1'b1;

  typedef enum logic [1:0] {RD_NONE, RD_IDX, RD_NEXT, RD_PREV} rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE, WR_INIT, WR_SPLIT, WR_COPY, WR_JOIN_PREV, WR_JOIN_NEXT, WR_NEW
  } wr_sel_e;

  typedef enum logic [2:0] {IDX_HOLD, IDX_INC, IDX_DEC, IDX_LOAD_CNT} idx_op_e;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_e;
  typedef enum logic [1:0] {FREE_HOLD, FREE_ADD, FREE_SUB} free_op_e;

  typedef struct packed {
    logic                init;
    logic                load;
    rd_sel_e             rd;
    wr_sel_e             wr;
    idx_op_e             idx;
    cnt_op_e             cnt;
    free_op_e            fr;
    logic                save_prev;
    logic                save_ins;
    logic                set_addr;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic zero;
    logic range_bad;
    logic idx_lt_cnt;
    logic idx1_lt_cnt;
    logic idx_gt_ins;
    logic fit_eq;
    logic fit_gt;
    logic base_lt_blk;
    logic overlap;
    logic join_prev;
    logic join_next;
    logic full;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/ffea_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module ffea_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ffea_dpath.sv =====
// Datapath: configuration, extent table RAM, index and count registers,
// compare flags. Depends on ffea_pkg and ffea_ram.
`default_nettype none
module ffea_dpath import ffea_pkg::*; #(
  parameter int unsigned MAX_EXTENTS = 64,
  parameter int unsigned BLOCK_BYTES = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  input  wire logic                mode_i,
  input  wire logic [31:0]         block_address_i,
  input  wire logic [31:0]         byte_count_i,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [31:0]              granted_address_o,
  output logic [31:0]              free_total_o
);
  localparam int unsigned AW    = $clog2(MAX_EXTENTS);
  localparam int unsigned CW    = $clog2(MAX_EXTENTS + 1);
  localparam logic [32:0] RND33 = 33'(BLOCK_BYTES - 1);
  localparam logic [31:0] RND32 = 32'(BLOCK_BYTES - 1);

  logic [31:0] cfg_start_q, cfg_len_q, eff_start_q, eff_len_q, free_q, addr_q, blk_q;
  logic [32:0] n_q;
  logic        mode_q, has_prev_q;
  logic [STATUS_W-1:0] status_q;
  logic [CW-1:0] count_q, idx_q, ins_q;
  logic [ENTRY_W-1:0] prev_q, rdata, wdata;
  logic [AW-1:0] raddr, waddr;
  logic          we;

  // effective region from the registers
  logic [31:0] eff_start, len_trunc, eff_len;
  logic [32:0] room;
  assign eff_start = (cfg_start_q + RND32) & ~RND32;
  assign len_trunc = cfg_len_q & ~RND32;
  assign room      = 33'h1_0000_0000 - {1'b0, eff_start};
  assign eff_len   = ({1'b0, len_trunc} > room) ? room[31:0] : len_trunc;

  logic [31:0] rbase, rsize, pbase, psize;
  assign rbase = rdata[63:32];
  assign rsize = rdata[31:0];
  assign pbase = prev_q[63:32];
  assign psize = prev_q[31:0];

  logic [32:0] top, blk_end;
  logic [33:0] reg_end;
  logic        has_next;
  assign top      = {1'b0, pbase} + {1'b0, psize};
  assign blk_end  = {1'b0, blk_q} + n_q;
  assign reg_end  = {2'b0, eff_start_q} + {2'b0, eff_len_q};
  assign has_next = idx_q < count_q;

  always_comb begin
    sts_o.mode        = mode_q;
    sts_o.zero        = (n_q == 33'd0);
    sts_o.range_bad   = (blk_q < eff_start_q) || ({1'b0, blk_end} > reg_end);
    sts_o.idx_lt_cnt  = has_next;
    sts_o.idx1_lt_cnt = ({1'b0, idx_q} + (CW+1)'(1)) < {1'b0, count_q};
    sts_o.idx_gt_ins  = idx_q > ins_q;
    sts_o.fit_eq      = ({1'b0, rsize} == n_q);
    sts_o.fit_gt      = ({1'b0, rsize} > n_q);
    sts_o.base_lt_blk = rbase < blk_q;
    sts_o.overlap     = (has_prev_q && ({1'b0, blk_q} < top)) ||
                        (has_next && (blk_end > {1'b0, rbase}));
    sts_o.join_prev   = has_prev_q && (top == {1'b0, blk_q});
    sts_o.join_next   = has_next && (blk_end == {1'b0, rbase});
    sts_o.full        = count_q >= CW'(MAX_EXTENTS);
  end

  always_comb begin
    unique case (cmd_i.rd)
      RD_NEXT: raddr = AW'(idx_q + CW'(1));
      RD_PREV: raddr = AW'(idx_q - CW'(1));
      default: raddr = idx_q[AW-1:0];
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = idx_q[AW-1:0];
    wdata = rdata;
    unique case (cmd_i.wr)
      WR_NONE:  we = 1'b0;
      WR_INIT: begin
        waddr = '0;
        wdata = {eff_start, eff_len};
      end
      WR_SPLIT: wdata = {rbase + n_q[31:0], rsize - n_q[31:0]};
      WR_COPY:  wdata = rdata;
      WR_JOIN_PREV: begin
        waddr = AW'(idx_q - CW'(1));
        wdata = {pbase, psize + n_q[31:0] + (sts_o.join_next ? rsize : 32'd0)};
      end
      WR_JOIN_NEXT: wdata = {blk_q, rsize + n_q[31:0]};
      WR_NEW:       wdata = {blk_q, n_q[31:0]};
      default:      we = 1'b0;
    endcase
  end

  ffea_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_EXTENTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd != RD_NONE),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_start_q <= '0;
      cfg_len_q   <= '0;
      eff_start_q <= '0;
      eff_len_q   <= '0;
      count_q     <= '0;
      free_q      <= '0;
      idx_q       <= '0;
      ins_q       <= '0;
      has_prev_q  <= 1'b0;
      status_q    <= ST_OK;
      addr_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_REGION_START:  cfg_start_q <= cfg_data_i;
          CFG_REGION_LENGTH: cfg_len_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.init) begin
        eff_start_q <= eff_start;
        eff_len_q   <= eff_len;
        count_q     <= CW'(eff_len != 32'd0);
        free_q      <= eff_len;
      end
      if (cmd_i.load || cmd_i.init) begin
        idx_q      <= '0;
        has_prev_q <= 1'b0;
        addr_q     <= '0;
        status_q   <= ST_OK;
      end else begin
        unique case (cmd_i.idx)
          IDX_INC:      idx_q <= idx_q + CW'(1);
          IDX_DEC:      idx_q <= idx_q - CW'(1);
          IDX_LOAD_CNT: idx_q <= count_q;
          default: ;
        endcase
      end
      unique case (cmd_i.cnt)
        CNT_INC: count_q <= count_q + CW'(1);
        CNT_DEC: count_q <= count_q - CW'(1);
        default: ;
      endcase
      unique case (cmd_i.fr)
        FREE_ADD: free_q <= free_q + n_q[31:0];
        FREE_SUB: free_q <= free_q - n_q[31:0];
        default: ;
      endcase
      if (cmd_i.save_prev) has_prev_q <= 1'b1;
      if (cmd_i.save_ins)  ins_q <= idx_q;
      if (cmd_i.set_addr)  addr_q <= rbase;
      if (cmd_i.set_status) status_q <= cmd_i.status_code;
    end
  end

  // transaction payload and scan register, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      blk_q  <= block_address_i;
      n_q    <= ({1'b0, byte_count_i} + RND33) & ~RND33;
    end
    if (cmd_i.save_prev) prev_q <= rdata;
  end

  assign status_o          = status_q;
  assign granted_address_o = addr_q;
  assign free_total_o      = free_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_EXTENTS)) else $error("extent count beyond table depth");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= count_q) else $error("table index past extent count");
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q != ST_OK) |-> (addr_q == 32'd0)) else $error("address on failed request");

endmodule
`default_nettype wire

// ===== hdl/ffea_ctrl.sv =====
// Controller state machine: sequences the table scans and entry shifts.
// Depends on ffea_pkg.
`default_nettype none
module ffea_ctrl import ffea_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire logic cfg_we_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      busy,
  output logic      done_o
);
  typedef enum logic [12:0] {
    S_INIT   = 13'h0001, S_IDLE  = 13'h0002, S_CHECK = 13'h0004,
    S_A_RD   = 13'h0008, S_A_CK  = 13'h0010, S_R_RD  = 13'h0020,
    S_R_WR   = 13'h0040, S_F_RD  = 13'h0080, S_F_CK  = 13'h0100,
    S_F_DEC  = 13'h0200, S_I_RD  = 13'h0400, S_I_WR  = 13'h0800,
    S_FINISH = 13'h1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{init: 1'b0, load: 1'b0, rd: RD_NONE, wr: WR_NONE, idx: IDX_HOLD,
                cnt: CNT_HOLD, fr: FREE_HOLD, save_prev: 1'b0, save_ins: 1'b0,
                set_addr: 1'b0, set_status: 1'b0, status_code: ST_OK};
    unique case (state_q)
      S_INIT: begin
        cmd_o.init = 1'b1;
        cmd_o.wr   = WR_INIT;
        state_d    = S_IDLE;
      end
      S_IDLE: begin
        priority if (cfg_we_i) begin
          state_d = S_INIT;
        end else if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts_i.zero) begin
          cmd_o.set_status = 1'b1;  cmd_o.status_code = ST_ZERO;
          state_d = S_FINISH;
        end else if (!sts_i.mode) begin
          state_d = S_A_RD;
        end else if (sts_i.range_bad) begin
          cmd_o.set_status = 1'b1;  cmd_o.status_code = ST_RANGE;
          state_d = S_FINISH;
        end else begin
          state_d = S_F_RD;
        end
      end
      S_A_RD: begin
        if (sts_i.idx_lt_cnt) begin
          cmd_o.rd = RD_IDX;
          state_d  = S_A_CK;
        end else begin
          cmd_o.set_status = 1'b1;  cmd_o.status_code = ST_NOFIT;
          state_d = S_FINISH;
        end
      end
      S_A_CK: begin
        priority if (sts_i.fit_eq) begin
          cmd_o.set_addr = 1'b1;
          cmd_o.fr       = FREE_SUB;
          state_d        = S_R_RD;
        end else if (sts_i.fit_gt) begin
          cmd_o.set_addr   = 1'b1;
          cmd_o.wr         = WR_SPLIT;
          cmd_o.fr         = FREE_SUB;
          cmd_o.set_status = 1'b1;
          state_d          = S_FINISH;
        end else begin
          cmd_o.idx = IDX_INC;
          state_d   = S_A_RD;
        end
      end
      S_R_RD: begin
        if (sts_i.idx1_lt_cnt) begin
          cmd_o.rd = RD_NEXT;
          state_d  = S_R_WR;
        end else begin
          cmd_o.cnt        = CNT_DEC;
          cmd_o.set_status = 1'b1;
          state_d          = S_FINISH;
        end
      end
      S_R_WR: begin
        cmd_o.wr  = WR_COPY;
        cmd_o.idx = IDX_INC;
        state_d   = S_R_RD;
      end
      S_F_RD: begin
        if (sts_i.idx_lt_cnt) begin
          cmd_o.rd = RD_IDX;
          state_d  = S_F_CK;
        end else begin
          state_d = S_F_DEC;
        end
      end
      S_F_CK: begin
        if (sts_i.base_lt_blk) begin
          cmd_o.save_prev = 1'b1;
          cmd_o.idx       = IDX_INC;
          state_d         = S_F_RD;
        end else begin
          state_d = S_F_DEC;
        end
      end
      S_F_DEC: begin
        priority if (sts_i.overlap) begin
          cmd_o.set_status = 1'b1;  cmd_o.status_code = ST_OVERLAP;
          state_d = S_FINISH;
        end else if (sts_i.join_prev) begin
          cmd_o.wr = WR_JOIN_PREV;
          cmd_o.fr = FREE_ADD;
          if (sts_i.join_next) begin
            state_d = S_R_RD;
          end else begin
            cmd_o.set_status = 1'b1;
            state_d          = S_FINISH;
          end
        end else if (sts_i.join_next) begin
          cmd_o.wr         = WR_JOIN_NEXT;
          cmd_o.fr         = FREE_ADD;
          cmd_o.set_status = 1'b1;
          state_d          = S_FINISH;
        end else if (sts_i.full) begin
          cmd_o.set_status = 1'b1;  cmd_o.status_code = ST_FULL;
          state_d = S_FINISH;
        end else begin
          cmd_o.save_ins = 1'b1;
          cmd_o.idx      = IDX_LOAD_CNT;
          cmd_o.fr       = FREE_ADD;
          state_d        = S_I_RD;
        end
      end
      S_I_RD: begin
        if (sts_i.idx_gt_ins) begin
          cmd_o.rd = RD_PREV;
          state_d  = S_I_WR;
        end else begin
          cmd_o.wr         = WR_NEW;
          cmd_o.cnt        = CNT_INC;
          cmd_o.set_status = 1'b1;
          state_d          = S_FINISH;
        end
      end
      S_I_WR: begin
        cmd_o.wr  = WR_COPY;
        cmd_o.idx = IDX_DEC;
        state_d   = S_I_RD;
      end
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_FINISH);
endmodule
`default_nettype wire

// ===== hdl/first_fit_extent_allocator.sv =====
// Top level of the first-fit extent allocator with coalescing.
// Depends on ffea_pkg, ffea_ctrl, ffea_dpath (which holds ffea_ram).
//
// Usage:
//   Request channel: drive mode_i, block_address_i and byte_count_i and raise
//   start; the transaction is taken at a clock edge with start high and busy
//   low. mode 0 allocates, mode 1 frees. Sizes round up to BLOCK_BYTES, which
//   must be a power of two.
//   Result channel: done_o is high for exactly one cycle with status_o,
//   granted_address_o and free_total_o valid. The receiver cannot stall.
//   Config: cfg_we_i with cfg_index_i (0 region start, 1 region length) and
//   cfg_data_i, written only while idle: the user must keep to this, the
//   block itself does not enforce it. Each write rebuilds the table to one
//   extent over the region (none if it is empty) in S_INIT, while busy is high.
//   Reset: the region is empty; busy stays high for one cycle after reset
//   while entry 0 of the table is written.
//   Sequencing: each table entry visited takes a RAM read state, then a
//   compare or shift-write state, through the single registered read port.
//   One transaction is in flight at a time.
`default_nettype none
module first_fit_extent_allocator import ffea_pkg::*; #(
  parameter int unsigned MAX_EXTENTS = 64,
  parameter int unsigned BLOCK_BYTES = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                mode_i,
  input  wire logic [31:0]         block_address_i,
  input  wire logic [31:0]         byte_count_i,
  output logic                     done_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [31:0]              granted_address_o,
  output logic [31:0]              free_total_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [31:0]         cfg_data_i
);
  cmd_t cmd;
  sts_t sts;

  // sequence scans, shifts and result strobe
  ffea_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cfg_we_i (cfg_we_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  // hold region, extent table and running totals
  ffea_dpath #(.MAX_EXTENTS(MAX_EXTENTS), .BLOCK_BYTES(BLOCK_BYTES)) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .mode_i            (mode_i),
    .block_address_i   (block_address_i),
    .byte_count_i      (byte_count_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .free_total_o      (free_total_o)
  );
endmodule
`default_nettype wire

// ===== sim/first_fit_extent_allocator_tb.sv =====
// Self-checking testbench for the first-fit extent allocator: directed table, then random traffic.
// Predicts each result with its own model of the extent table. Depends on ffea_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module first_fit_extent_allocator_tb;
  import ffea_pkg::*;

  localparam int unsigned EXTENTS  = 64;
  localparam int unsigned BLK      = 8;
  localparam int unsigned WD_LIMIT = 20000;  // idle cycles before giving up
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [31:0]         gaddr;
    logic [31:0]         ftotal;
  } grant_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] size;
  } block_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        mode;     // request mode, or register index for a config row
    logic [31:0] addr;
    logic [31:0] cnt;      // byte count, or register data for a config row
    logic        typed;    // expected result written out below
    grant_t      want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic mode_i = 1'b0;
  logic [31:0] block_address_i = '0;
  logic [31:0] byte_count_i = '0;
  logic done_o;
  logic [STATUS_W-1:0] status_o;
  logic [31:0] granted_address_o;
  logic [31:0] free_total_o;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  always #6 clk_i = ~clk_i;

  first_fit_extent_allocator dut (.*);

  // Predictor state: a private copy of the free-extent table.
  logic [31:0] reg_start, reg_length;
  logic [31:0] ext_base [EXTENTS];
  logic [31:0] ext_size [EXTENTS];
  int unsigned ext_cnt;
  logic [31:0] free_sum;
  logic [31:0] win_start;
  longint unsigned win_len;

  grant_t pending_grants[$];
  block_t owned[$];
  int unsigned mismatches = 0;
  int unsigned n_alloc = 0, n_free = 0, n_full = 0, n_split = 0, n_regions = 0;
  int unsigned idle_cycles = 0;

  function automatic longint unsigned blk_round(longint unsigned x);
    return ((x + BLK - 1) / BLK) * BLK;
  endfunction

  function automatic void rebuild_table();
    longint unsigned len, room;
    win_start = 32'(blk_round(reg_start));
    len  = (reg_length / BLK) * BLK;
    room = 64'h1_0000_0000 - win_start;
    if (len > room) len = (room / BLK) * BLK;
    win_len = len;
    foreach (ext_base[k]) begin
      ext_base[k] = '0;
      ext_size[k] = '0;
    end
    ext_base[0] = win_start;
    ext_size[0] = len[31:0];
    ext_cnt  = (len != 0) ? 1 : 0;
    free_sum = len[31:0];
  endfunction

  function automatic void drop_extent(int unsigned i);
    for (int unsigned k = i; k + 1 < ext_cnt; k++) begin
      ext_base[k] = ext_base[k+1];
      ext_size[k] = ext_size[k+1];
    end
    if (ext_cnt > 0) ext_cnt--;
  endfunction

  function automatic logic [STATUS_W-1:0] carve(longint unsigned n, output logic [31:0] ga);
    ga = '0;
    for (int unsigned i = 0; i < ext_cnt; i++) begin
      if (ext_size[i] == n) begin
        ga = ext_base[i];
        drop_extent(i);
        free_sum -= n[31:0];
        return ST_OK;
      end
      if (ext_size[i] > n) begin
        ga = ext_base[i];
        ext_base[i] = ext_base[i] + n[31:0];
        ext_size[i] = ext_size[i] - n[31:0];
        free_sum -= n[31:0];
        return ST_OK;
      end
    end
    return ST_NOFIT;
  endfunction

  function automatic logic [STATUS_W-1:0] give_back(longint unsigned b, longint unsigned n);
    int unsigned i;
    bit has_prev, has_next, jp, jn;
    longint unsigned top;
    i = 0;
    top = 0;
    if (b < win_start || b + n > win_start + win_len) return ST_RANGE;
    while (i < ext_cnt && ext_base[i] < b) i++;
    has_prev = (i > 0);
    has_next = (i < ext_cnt);
    if (has_prev) top = longint'(ext_base[i-1]) + ext_size[i-1];
    if ((has_prev && b < top) || (has_next && b + n > ext_base[i])) return ST_OVERLAP;
    jp = has_prev && top == b;
    jn = has_next && b + n == ext_base[i];
    if (jp) begin
      ext_size[i-1] = ext_size[i-1] + n[31:0];
      if (jn) begin
        ext_size[i-1] += ext_size[i];
        drop_extent(i);
      end
    end else if (jn) begin
      ext_base[i] = b[31:0];
      ext_size[i] = ext_size[i] + n[31:0];
    end else begin
      if (ext_cnt >= EXTENTS) return ST_FULL;
      for (int unsigned k = ext_cnt; k > i; k--) begin
        ext_base[k] = ext_base[k-1];
        ext_size[k] = ext_size[k-1];
      end
      ext_base[i] = b[31:0];
      ext_size[i] = n[31:0];
      ext_cnt++;
    end
    free_sum = free_sum + n[31:0];
    return ST_OK;
  endfunction

  // Work out the result of one accepted transaction and advance the table.
  function automatic grant_t predict_grant(logic m, logic [31:0] a, logic [31:0] c);
    grant_t g;
    g.gaddr = '0;
    if (c == 0) g.status = ST_ZERO;
    else if (m == MODE_ALLOC) begin
      g.status = carve(blk_round(c), g.gaddr);
      if (g.status != ST_OK) g.gaddr = '0;
    end else g.status = give_back(a, blk_round(c));
    g.ftotal = free_sum;
    return g;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one transaction; hold start until the block takes it, then idle a random gap.
  // With a zero gap start stays high into the next call.
  task automatic issue(logic m, logic [31:0] a, logic [31:0] c, logic typed = 1'b0,
                       grant_t want = '0);
    grant_t g;
    int unsigned gap;
    start <= 1'b1;
    mode_i <= m;
    block_address_i <= a;
    byte_count_i <= c;
    do @(posedge clk_i); while (busy);
    g = predict_grant(m, a, c);
    pending_grants.push_back(typed ? want : g);
    if (m == MODE_ALLOC) n_alloc++; else n_free++;
    if (g.status == ST_FULL) n_full++;
    if (m == MODE_ALLOC && g.status == ST_OK)
      owned.push_back({g.gaddr, 32'(blk_round(c))});
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drain, let the block settle, then write one register; the table rebuilds.
  task automatic write_reg(logic idx, logic [31:0] data);
    if (start) begin
      @(posedge clk_i);
      start <= 1'b0;
    end
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_data_i <= $urandom;
    if (idx == CFG_REGION_START) reg_start = data; else reg_length = data;
    rebuild_table();
    owned.delete();
  endtask

  task automatic set_region(logic [31:0] s, logic [31:0] len);
    write_reg(CFG_REGION_START, s);
    write_reg(CFG_REGION_LENGTH, len);
    n_regions++;
  endtask

  // Return a whole owned block, or a piece of it to fragment the table.
  task automatic free_owned();
    int unsigned k;
    block_t b;
    k = $urandom_range(0, owned.size() - 1);
    b = owned[k];
    owned.delete(k);
    if (b.size > BLK && $urandom_range(0, 3) == 0) begin
      issue(MODE_FREE, b.addr, BLK);
      n_split++;
    end else issue(MODE_FREE, b.addr, b.size - $urandom_range(0, BLK - 1));
  endtask

  task automatic random_request();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45 || (r < 80 && owned.size() == 0)) begin
      issue(MODE_ALLOC, $urandom,
            ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(1, 48));
    end else if (r < 80) begin
      free_owned();
    end else if (r < 90 && win_len != 0) begin
      issue(MODE_FREE, win_start + $urandom_range(0, win_len > 64'hFFFF_FFFF ?
            32'hFFFF_FFFF : win_len[31:0]), $urandom_range(1, 64));
    end else begin
      issue(1'($urandom_range(0, 1)), $urandom,
            ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
    end
  endtask

  // Directed rows; the region after reset is empty.
  row_t dir_rows[] = '{
    '{ROW_REQ, MODE_ALLOC, 32'h0, 32'hFFFF_FFFF, 1'b1, '{ST_NOFIT, 32'h0, 32'h0}},
    '{ROW_REQ, MODE_FREE,  32'h0, 32'h8,         1'b1, '{ST_RANGE, 32'h0, 32'h0}},
    '{ROW_REQ, MODE_ALLOC, 32'h0, 32'h0,         1'b1, '{ST_ZERO,  32'h0, 32'h0}},
    '{ROW_REQ, MODE_FREE,  32'hFFFF_FFFF, 32'h0, 1'b1, '{ST_ZERO,  32'h0, 32'h0}},
    '{ROW_CFG, CFG_REGION_START,  32'h0, 32'h1003, 1'b0, '0},
    '{ROW_CFG, CFG_REGION_LENGTH, 32'h0, 32'h107,  1'b0, '0},
    '{ROW_REQ, MODE_ALLOC, 32'h0, 32'h1,         1'b1, '{ST_OK, 32'h1008, 32'hF8}},
    '{ROW_REQ, MODE_ALLOC, 32'h0, 32'h10,        1'b1, '{ST_OK, 32'h1010, 32'hE8}},
    '{ROW_REQ, MODE_ALLOC, 32'h0, 32'hFFFF_FFFF, 1'b1, '{ST_NOFIT, 32'h0, 32'hE8}},
    '{ROW_REQ, MODE_FREE,  32'h1000, 32'h8,      1'b1, '{ST_RANGE, 32'h0, 32'hE8}},
    '{ROW_REQ, MODE_FREE,  32'h1100, 32'h8,      1'b0, '0},
    '{ROW_REQ, MODE_FREE,  32'h1010, 32'h10,     1'b0, '0},
    '{ROW_REQ, MODE_FREE,  32'h1008, 32'h1,      1'b0, '0},
    '{ROW_REQ, MODE_ALLOC, 32'h0, 32'h100,       1'b0, '0},
    '{ROW_REQ, MODE_FREE,  32'h1040, 32'h8,      1'b0, '0},
    '{ROW_REQ, MODE_FREE,  32'h1048, 32'h8,      1'b0, '0},
    '{ROW_REQ, MODE_FREE,  32'h1030, 32'h8,      1'b0, '0},
    '{ROW_REQ, MODE_FREE,  32'h1038, 32'h8,      1'b0, '0},
    '{ROW_REQ, MODE_FREE,  32'h1039, 32'h3,      1'b0, '0},
    '{ROW_REQ, MODE_FREE,  32'h1101, 32'h3,      1'b0, '0},
    '{ROW_REQ, MODE_FREE,  32'h1050, 32'h7,      1'b0, '0},
    '{ROW_REQ, MODE_FREE,  32'h1005, 32'h3,      1'b0, '0},
    '{ROW_REQ, MODE_ALLOC, 32'h0, 32'h28,        1'b0, '0}
  };

  // Check every result against the oldest expectation.
  always @(posedge clk_i) begin
    grant_t w;
    if (rst_ni && done_o) begin
      if (pending_grants.size() == 0) begin
        $display("[%0t] MISMATCH result with no request outstanding", $realtime);
        mismatches++;
      end else begin
        w = pending_grants.pop_front();
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (granted_address_o !== w.gaddr)
          report_mismatch("granted_address", granted_address_o, w.gaddr);
        if (free_total_o !== w.ftotal) report_mismatch("free_total", free_total_o, w.ftotal);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy) || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WD_LIMIT) begin
      $display("[%0t] watchdog expired", $realtime);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    reg_start = '0;
    reg_length = '0;
    rebuild_table();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].mode, dir_rows[i].cnt);
      else issue(dir_rows[i].mode, dir_rows[i].addr, dir_rows[i].cnt,
                 dir_rows[i].typed, dir_rows[i].want);
    end

    // Fill the table: 130 single blocks, free alternate ones, an isolated one (full), then merges.
    set_region(32'h0000_2000, 130 * BLK);
    for (int k = 0; k < 130; k++) issue(MODE_ALLOC, $urandom, $urandom_range(1, BLK));
    for (int k = 0; k < 128; k += 2) issue(MODE_FREE, 32'h2000 + k * BLK, BLK);
    issue(MODE_FREE, 32'h2000 + 128 * BLK, BLK);
    issue(MODE_FREE, 32'h2000 + 127 * BLK, BLK);
    issue(MODE_FREE, 32'h2000 + 128 * BLK, BLK);

    // Region extremes, then random regions of mostly small size.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_region(32'h0, 32'h400);
        1: set_region(32'hFFFF_FFF9, 32'hFFFF_FFFF);
        2: set_region(32'hFFFF_F001, 32'hFFFF_FFFF);
        3: set_region($urandom, 32'h0);
        default: set_region($urandom, $urandom_range(8, 2048));
      endcase
      repeat ((p == 3) ? 10 : 60) random_request();
    end

    if (start) begin
      @(posedge clk_i);
      start <= 1'b0;
    end
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("Covered %0d allocates and %0d frees over %0d region settings,",
             n_alloc, n_free, n_regions);
    $display("with %0d table-full rejections and %0d partial returns.", n_full, n_split);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

// ===== first_fit_extent_allocator.f =====
hdl/ffea_pkg.sv
hdl/ffea_ram.sv
hdl/ffea_dpath.sv
hdl/ffea_ctrl.sv
hdl/first_fit_extent_allocator.sv
sim/first_fit_extent_allocator_tb.sv
